@@ src/wgm_pkg.sv @@
// shared types, constants and helpers for the wildcard glob matcher
package wgm_pkg;

  localparam int PATTERN_CHARS_DEF = 32;
  localparam int PAT_WORDS         = 4;
  localparam int PAT_BYTES         = 32;
  localparam int CFG_ADDR_W        = 6;
  localparam int CFG_DATA_W        = 64;
  localparam int PAT_LEN_W         = 6;

  localparam logic [7:0] STAR_CODE   = 8'h2A;
  localparam logic [7:0] ANY_CODE    = 8'h3F;
  localparam logic [7:0] END_CODE    = 8'h00;
  localparam logic [7:0] LOWER_A     = 8'h61;
  localparam logic [7:0] LOWER_Z     = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [2:0] {
    REG_PAT_WORD0 = 3'd0,
    REG_PAT_WORD1 = 3'd1,
    REG_PAT_WORD2 = 3'd2,
    REG_PAT_WORD3 = 3'd3,
    REG_PAT_LEN   = 3'd4,
    REG_CASE_SENS = 3'd5
  } wgm_reg_t;

  // per pattern position: its byte and where it sits relative to the live length
  typedef struct packed {
    logic [7:0] pat;
    logic       in_use;   // position holds a pattern byte that is consumed
    logic       pos_ok;   // position is at or below the effective length
  } wgm_pos_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && (c inside {[LOWER_A:LOWER_Z]})) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ src/wildcard_glob_matcher_top.sv @@
// top level of the wildcard glob matcher: config port, cell chain and result register
//
// Usage: program the pattern over the cfg_ APB port (four 64-bit pattern words at
// byte addresses 0, 8, 16, 24, length at 32, case flag at 40), then stream string
// bytes on the in_ channel, one byte per word in in_tdata[7:0]. A zero byte ends
// the string: one word comes out on the out_ channel with out_tdata[0] set when the
// whole string matched, and matching restarts at the first pattern position.
// Non-zero bytes produce no output word.
// Throughput: one byte per cycle while in_tready is high. Every pattern position is
// a cell of the chain, all cells update together, and the '*' skip-over ripples
// through the chain within the cycle like a carry.
// The result is registered into the output register as the zero byte is taken.
// Stall: the output register holds a waiting result; in_tready drops only while
// a result waits and out_tready is low, and rises again as soon as it is taken.
// Reset (synchronous, rst_n low): pattern words clear, length becomes 1, compare is
// case-insensitive, only the start position is live and the output is empty.
// Change the configuration only with no result pending.
module wildcard_glob_matcher_top #(
  parameter int PatternChars = wgm_pkg::PATTERN_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] char_code
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,   // [0] matched, [7:1] zero
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import wgm_pkg::*;

  wgm_pos_t [PatternChars:0] pos;
  logic                      fold_en;
  logic [7:0]                char_fold;
  logic                      in_acc;
  logic                      restart;
  logic                      step_en;
  logic [PatternChars+1:0]   skip;
  logic [PatternChars+1:0]   adv;
  logic [PatternChars:0]     cur;
  logic [PatternChars:0]     act;
  logic [PatternChars:0]     end_pos;
  logic                      match;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      out_matched_r;

  assign cfg_pready = 1'b1;

  wgm_cfg_regs #(
    .PatternChars(PatternChars)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .fold_en    (fold_en),
    .pos        (pos)
  );

  assign in_tready = ~out_valid_r | out_tready;
  assign in_acc    = in_tvalid & in_tready;
  assign restart   = in_acc & (in_tdata == END_CODE);
  assign step_en   = in_acc & (in_tdata != END_CODE);
  assign char_fold = fold_char(in_tdata, fold_en);

  assign skip[0] = 1'b0;
  assign adv[0]  = 1'b0;

  for (genvar i = 0; i <= PatternChars; i++) begin : g_cell
    wgm_cell #(
      .StartCell(i == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .pos      (pos[i]),
      .char_fold(char_fold),
      .fold_en  (fold_en),
      .step_en  (step_en),
      .restart  (restart),
      .skip_in  (skip[i]),
      .adv_in   (adv[i]),
      .skip_out (skip[i+1]),
      .adv_out  (adv[i+1]),
      .cur      (cur[i]),
      .act      (act[i])
    );
    // the end of the pattern is the first position that is not in use
    assign end_pos[i] = pos[i].pos_ok & ~pos[i].in_use;
  end

  assign match = |(cur & end_pos);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (restart) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (restart) begin
      out_matched_r <= match;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_matched_r};

  // exactly one position marks the end of the pattern
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(end_pos))
    else $error("pattern end position not unique");

  // nothing is handed past the last cell
  assert property (@(posedge clk) disable iff (!rst_n)
    !skip[PatternChars+1] && !adv[PatternChars+1])
    else $error("live position ran off the cell chain");

  // a zero byte brings a result and leaves only the start position live
  assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> out_tvalid && (act == (PatternChars+1)'(1)))
    else $error("string end did not restart the matcher");

  // input back-pressure comes only from a waiting result
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a pending result");

endmodule

@@ src/wgm_cfg_regs.sv @@
// configuration registers and per-position pattern decode
module wgm_cfg_regs #(
  parameter int PatternChars = wgm_pkg::PATTERN_CHARS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [wgm_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [wgm_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  fold_en,
  output wgm_pkg::wgm_pos_t [PatternChars:0]    pos
);
  import wgm_pkg::*;

  logic [CFG_DATA_W-1:0] pat_word_r [PAT_WORDS];
  logic [PAT_LEN_W-1:0]  pat_len_r;
  logic                  case_sens_r;
  logic                  wr_en;
  wgm_reg_t              reg_idx;
  logic [7:0]            pat_byte [PatternChars+1];
  logic [PatternChars:0] nz_chain;

  assign wr_en   = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx = wgm_reg_t'(cfg_paddr[CFG_ADDR_W-1:3]);
  assign fold_en = ~case_sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
      pat_len_r   <= PAT_LEN_W'(1);
      case_sens_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PAT_WORD0: pat_word_r[0] <= cfg_pwdata;
        REG_PAT_WORD1: pat_word_r[1] <= cfg_pwdata;
        REG_PAT_WORD2: pat_word_r[2] <= cfg_pwdata;
        REG_PAT_WORD3: pat_word_r[3] <= cfg_pwdata;
        REG_PAT_LEN:   pat_len_r     <= cfg_pwdata[PAT_LEN_W-1:0];
        REG_CASE_SENS: case_sens_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAT_WORD0: cfg_prdata = pat_word_r[0];
      REG_PAT_WORD1: cfg_prdata = pat_word_r[1];
      REG_PAT_WORD2: cfg_prdata = pat_word_r[2];
      REG_PAT_WORD3: cfg_prdata = pat_word_r[3];
      REG_PAT_LEN:   cfg_prdata = CFG_DATA_W'(pat_len_r);
      REG_CASE_SENS: cfg_prdata = CFG_DATA_W'(case_sens_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // a zero byte ends the pattern, and positions past the stored words read as zero
  for (genvar k = 0; k <= PatternChars; k++) begin : g_pos
    if (k < PAT_BYTES) begin : g_byte
      localparam int WordSel = k / 8;
      localparam int ByteSel = k % 8;
      assign pat_byte[k] = pat_word_r[WordSel][ByteSel*8 +: 8];
    end else begin : g_zero
      assign pat_byte[k] = END_CODE;
    end

    if (k == 0) begin : g_first
      assign nz_chain[k]  = (pat_byte[k] != END_CODE);
      assign pos[k].pos_ok = 1'b1;
    end else begin : g_rest
      assign nz_chain[k]  = nz_chain[k-1] & (pat_byte[k] != END_CODE);
      assign pos[k].pos_ok = pos[k-1].in_use;
    end

    if (k == PatternChars) begin : g_tail
      assign pos[k].in_use = 1'b0;
    end else begin : g_body
      assign pos[k].in_use = nz_chain[k] & ({1'b0, pat_len_r} > (PAT_LEN_W+1)'(k));
    end

    assign pos[k].pat = pat_byte[k];
  end

endmodule

@@ src/wgm_cell.sv @@
// one pattern position: live bit, star skip-over and advance to the right neighbor
module wgm_cell #(
  parameter bit StartCell = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wgm_pkg::wgm_pos_t pos,
  input  logic [7:0]        char_fold,
  input  logic              fold_en,
  input  logic              step_en,
  input  logic              restart,
  input  logic              skip_in,
  input  logic              adv_in,
  output logic              skip_out,
  output logic              adv_out,
  output logic              cur,
  output logic              act
);
  import wgm_pkg::*;

  logic act_r;
  logic act_nxt;
  logic is_star;
  logic hit;

  assign is_star = (pos.pat == STAR_CODE);
  assign hit     = (pos.pat == ANY_CODE) || (fold_char(pos.pat, fold_en) == char_fold);

  // live after '*' closure from the left, masked beyond the effective length
  assign cur      = pos.pos_ok & (act_r | skip_in);
  assign skip_out = cur & pos.in_use & is_star;
  assign adv_out  = cur & pos.in_use & ~is_star & hit;
  assign act      = act_r;

  assign act_nxt = skip_out | adv_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= StartCell;
    end else if (restart) begin
      act_r <= StartCell;
    end else if (step_en) begin
      act_r <= act_nxt;
    end
  end

endmodule

@@ tb/wildcard_glob_matcher_top_tb.sv @@
// testbench for the wildcard glob matcher: pattern setups, string streams, match checks
`timescale 1ns / 100ps

module wildcard_glob_matcher_top_tb;
  import wgm_pkg::*;

  localparam int NPOS        = PATTERN_CHARS_DEF;
  localparam int ITEM_TARGET = 1120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 3;

  // expected match flags, built from a live-position model of the pattern
  class glob_scoreboard;
    logic [63:0]   pat_word [PAT_WORDS];
    logic [5:0]    pat_len;
    logic          case_sens;
    logic [NPOS:0] live;
    bit            match_q [$];
    int            errors;

    function new();
      foreach (pat_word[k]) pat_word[k] = '0;
      pat_len   = 6'd1;
      case_sens = 1'b0;
      live      = (NPOS+1)'(1);
      errors    = 0;
    endfunction

    function void write_reg(wgm_reg_t r, logic [63:0] v);
      case (r)
        REG_PAT_WORD0: pat_word[0] = v;
        REG_PAT_WORD1: pat_word[1] = v;
        REG_PAT_WORD2: pat_word[2] = v;
        REG_PAT_WORD3: pat_word[3] = v;
        REG_PAT_LEN:   pat_len = v[5:0];
        REG_CASE_SENS: case_sens = v[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pat_byte(int k);
      if (k >= PAT_BYTES) return 8'h00;
      return pat_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      if (!case_sens && (c inside {[LOWER_A:LOWER_Z]})) return c - CASE_OFFSET;
      return c;
    endfunction

    // length clamps to the position count and stops at the first zero byte
    function int live_len();
      int raw;
      raw = int'(pat_len);
      if (raw > NPOS) raw = NPOS;
      for (int k = 0; k < raw; k++)
        if (pat_byte(k) == END_CODE) return k;
      return raw;
    endfunction

    function void note_char(logic [7:0] c);
      logic [NPOS:0] cur;
      logic [NPOS:0] nxt;
      logic [7:0]    p;
      int            n;
      n   = live_len();
      cur = '0;
      nxt = '0;
      // star skip-over ripples forward through the live positions
      for (int i = 0; i <= n; i++) begin
        if (live[i]) cur[i] = 1'b1;
        if (cur[i] && i < n && pat_byte(i) == STAR_CODE) cur[i+1] = 1'b1;
      end
      if (c == END_CODE) begin
        match_q.push_back(cur[n]);
        live = (NPOS+1)'(1);
      end else begin
        for (int i = 0; i < n; i++) begin
          p = pat_byte(i);
          if (cur[i]) begin
            if (p == STAR_CODE) nxt[i] = 1'b1;
            else if (p == ANY_CODE || upcase(p) == upcase(c)) nxt[i+1] = 1'b1;
          end
        end
        live = nxt;
      end
    endfunction

    function void check_word(logic [7:0] d);
      bit exp_match;
      if (match_q.size() == 0) begin
        $error("unexpected result word: matched=%0d", d[0]);
        errors++;
        return;
      end
      exp_match = match_q.pop_front();
      if (d[0] !== exp_match) begin
        $error("matched: expected %0d, actual %0d", exp_match, d[0]);
        errors++;
      end
      if (d[7:1] !== 7'd0) begin
        $error("out_tdata[7:1]: expected 0, actual %0h", d[7:1]);
        errors++;
      end
    endfunction

    function int pending();
      return match_q.size();
    endfunction

    function void leftover_check();
      while (match_q.size() > 0) begin
        $error("matched: expected %0d, actual none", match_q.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;     // [7:0] char_code
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;    // [0] matched, [7:1] zero
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  glob_scoreboard sb;
  int             items_sent;
  int             cycle_count;
  int             rx_hold;
  bit             no_gaps;
  logic           cur_case;
  logic [7:0]     gen_pat [PAT_BYTES];
  int             gen_len;
  logic [7:0]     str_q [$];

  wildcard_glob_matcher_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, forced hold-off when asked
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if (no_gaps) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_word(out_tdata);
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_char(input logic [7:0] c);
    while (!no_gaps && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_char(c);
    items_sent++;
    @(negedge clk);
  endtask

  // leaves psel high so that writes can follow back to back
  task automatic cfg_write(input wgm_reg_t r, input logic [63:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {r, 3'b000};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(r, v);
    @(negedge clk);
  endtask

  task automatic program_pattern(input logic [63:0] w0, input logic [63:0] w1,
                                 input logic [63:0] w2, input logic [63:0] w3,
                                 input logic [5:0] len, input logic cs);
    cfg_write(REG_PAT_WORD0, w0);
    cfg_write(REG_PAT_WORD1, w1);
    cfg_write(REG_PAT_WORD2, w2);
    cfg_write(REG_PAT_WORD3, w3);
    cfg_write(REG_PAT_LEN, 64'(len));
    cfg_write(REG_CASE_SENS, 64'(cs));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_case = cs;
    @(negedge clk);
  endtask

  // all results in, plus a settle wait for a byte still in flight
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(3));
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(1)) return 8'($urandom_range(1, 255));
    return pick_letter();
  endfunction

  task automatic gen_and_program();
    logic [63:0] w [PAT_WORDS];
    logic [5:0]  len;
    int          sel;
    bit          all_ones;
    sel = $urandom_range(9);
    if (sel == 0) gen_len = 0;
    else if (sel == 1) gen_len = PAT_BYTES;
    else if (sel == 2) gen_len = $urandom_range(9, PAT_BYTES);
    else gen_len = $urandom_range(1, 8);
    all_ones = ($urandom_range(19) == 0);
    for (int k = 0; k < PAT_BYTES; k++) begin
      sel = $urandom_range(99);
      if (all_ones) gen_pat[k] = 8'hFF;
      else if (k >= gen_len) gen_pat[k] = 8'($urandom_range(255));
      else if (sel < 20) gen_pat[k] = STAR_CODE;
      else if (sel < 35) gen_pat[k] = ANY_CODE;
      else if (sel < 88) gen_pat[k] = pick_letter();
      else if (sel < 98) gen_pat[k] = 8'($urandom_range(1, 255));
      else gen_pat[k] = END_CODE;
      w[k / 8][(k % 8) * 8 +: 8] = gen_pat[k];
    end
    sel = $urandom_range(9);
    if (sel == 0) len = 6'($urandom_range(63));
    else if (sel == 1) len = 6'($urandom_range(33, 63));
    else len = 6'(gen_len);
    program_pattern(w[0], w[1], w[2], w[3], len, 1'($urandom_range(1)));
  endtask

  // mostly strings that fit the pattern, some with one byte broken, some pure noise
  task automatic build_string();
    logic [7:0] p;
    int         idx;
    str_q.delete();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(10)) str_q.push_back(rand_byte());
      return;
    end
    for (int k = 0; k < gen_len; k++) begin
      p = gen_pat[k];
      if (p == END_CODE) break;
      if (p == STAR_CODE) begin
        repeat ($urandom_range(3)) str_q.push_back(rand_byte());
      end else if (p == ANY_CODE) begin
        str_q.push_back(rand_byte());
      end else begin
        if (!cur_case && $urandom_range(1) &&
            (p inside {[8'h41:8'h5A], [LOWER_A:LOWER_Z]}))
          p = p ^ CASE_OFFSET;
        str_q.push_back(p);
      end
    end
    if ($urandom_range(3) == 0) begin
      idx = (str_q.size() > 0) ? $urandom_range(str_q.size() - 1) : 0;
      case ($urandom_range(2))
        0: if (str_q.size() > 0) str_q[idx] = rand_byte();
        1: if (str_q.size() > 0) str_q.delete(idx);
        default: str_q.push_back(rand_byte());
      endcase
    end
  endtask

  initial begin
    int phase;
    int nstr;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    items_sent  = 0;
    cycle_count = 0;
    rx_hold     = 0;
    no_gaps     = 1'b0;
    cur_case    = 1'b0;
    gen_len     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset pattern is a zero byte: empty pattern, only the empty string matches
    push_char(END_CODE);
    push_char("a");
    push_char(END_CODE);

    // "a*?C", case-insensitive
    wait_idle();
    program_pattern(64'h433F2A61, '0, '0, '0, 6'd4, 1'b0);
    push_char("A");
    push_char("x");
    push_char("y");
    push_char("c");
    push_char(END_CODE);

    // same pattern, exact compare, star matching nothing
    wait_idle();
    program_pattern(64'h433F2A61, '0, '0, '0, 6'd4, 1'b1);
    push_char("a");
    push_char("Z");
    push_char("C");
    push_char(END_CODE);

    // all stars with an oversized length
    wait_idle();
    program_pattern({8{STAR_CODE}}, {8{STAR_CODE}}, {8{STAR_CODE}}, {8{STAR_CODE}},
                    6'd63, 1'b0);
    push_char(8'hFF);
    push_char(8'h80);
    push_char(END_CODE);

    // bytes above 0x7F are never case-folded
    wait_idle();
    program_pattern(64'hE1, '0, '0, '0, 6'd1, 1'b0);
    push_char(8'hC1);
    push_char(END_CODE);

    // pattern swapped in the middle of a string keeps the live positions
    wait_idle();
    program_pattern(64'h6261, '0, '0, '0, 6'd2, 1'b0);
    push_char("a");
    wait_idle();
    program_pattern(64'h6278, '0, '0, '0, 6'd2, 1'b0);
    push_char("B");
    push_char(END_CODE);

    // zero byte inside the length cuts the pattern short
    wait_idle();
    program_pattern(64'h620061, '0, '0, '0, 6'd3, 1'b0);
    push_char("a");
    push_char(END_CODE);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      gen_and_program();
      no_gaps = (phase >= 6 && phase < 10);
      if (phase == 3) rx_hold = 150;
      nstr = $urandom_range(3, 8);
      for (int s = 0; s < nstr; s++) begin
        build_string();
        foreach (str_q[i]) push_char(str_q[i]);
        // now and then leave the string open across the next pattern change
        if (s != nstr - 1 || $urandom_range(5) != 0) push_char(END_CODE);
      end
      phase++;
    end
    no_gaps = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    sb.leftover_check();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
